FILE: hw/rtl/vtp_pkg.sv
// Shared types and constants of the vertex transform pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int unsigned DW = 32;
  // width of a row value before saturation: translation plus shifted sum
  localparam int unsigned SW = 67;

  localparam logic [1:0] OP_LOAD_PROJ   = 2'd0;
  localparam logic [1:0] OP_LOAD_SCREEN = 2'd1;
  localparam logic [1:0] OP_VERTEX      = 2'd2;

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DW-1){1'b0}}};

  // side data that travels with every item through the pipe
  typedef struct packed {
    logic          vtx;
    logic          sload;
    logic [3:0]    idx;
    logic [DW-1:0] coeff;
    logic [15:0]   norm_x;
    logic [15:0]   norm_y;
    logic [15:0]   norm_z;
  } tag_t;

  function automatic logic sat_ovf(input logic signed [SW-1:0] v);
    return !((&v[SW-1:DW-1]) || ~(|v[SW-1:DW-1]));
  endfunction

  function automatic fix_t sat_val(input logic signed [SW-1:0] v);
    if (sat_ovf(v)) begin
      return v[SW-1] ? FIX_MIN : FIX_MAX;
    end
    return fix_t'(v[DW-1:0]);
  endfunction

endpackage

FILE: hw/rtl/vertex_transform_perspective.sv
// Top level of the vertex transform: input stage, both matrix stores,
// projection rows, perspective divider, screen rows. Uses vtp_pkg, vtp_mat, vtp_div.
//
// Usage: one input channel (in_valid / in_stall) carries an item with an opcode.
// Opcode 0 writes a projection coefficient, opcode 1 a screen coefficient
// (index column*4+row), opcode 2 transforms a vertex; opcode 3 is dropped.
// Only vertex items give a result on the output channel (out_valid / out_stall).
// Coefficient writes take effect in item order: a vertex uses exactly the
// coefficients written by items accepted before it.
// Throughput: one item per cycle while the output is not stalled. Path: 25 register
// stages, made of the input register, two three-stage matrix units and the
// divider (setup stage, 16 quotient stages with two quotient bits per stage,
// finish stage).
// Reset: pipeline empties, both matrices return to identity.
// Stall: while out_valid is high and out_stall is high the whole pipe holds
// and in_stall is raised; nothing is lost or repeated.
`timescale 1ns / 1ps
module vertex_transform_perspective #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  coeff_index,
  input  logic signed [31:0] coeff_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] screen_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic        range_fault
);

  localparam vtp_pkg::fix_t ONE = vtp_pkg::fix_t'(64'(1) << FRAC_BITS);

  logic          adv;
  logic          accept;
  vtp_pkg::fix_t proj [16];
  vtp_pkg::fix_t scr  [16];

  logic          a_vld;
  vtp_pkg::tag_t a_tag;
  vtp_pkg::fix_t a_pos [3];

  logic          c_vld, c_fault;
  vtp_pkg::tag_t c_tag;
  vtp_pkg::fix_t c_row [4];

  logic          n_vld, n_fault;
  vtp_pkg::tag_t n_tag;
  vtp_pkg::fix_t n_ndc [3];

  vtp_pkg::tag_t o_tag;
  vtp_pkg::fix_t o_row [3];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // hold the projection matrix; write on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        proj[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
      end
    end else if (accept && opcode == vtp_pkg::OP_LOAD_PROJ) begin
      proj[coeff_index] <= coeff_value;
    end
  end

  // hold the screen matrix; write as the load item reaches the screen rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        scr[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
      end
    end else if (adv && n_vld && n_tag.sload) begin
      scr[n_tag.idx] <= n_tag.coeff;
    end
  end

  // input register: keep vertices and screen loads
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid &&
               (opcode == vtp_pkg::OP_VERTEX || opcode == vtp_pkg::OP_LOAD_SCREEN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag.vtx    <= (opcode == vtp_pkg::OP_VERTEX);
      a_tag.sload  <= (opcode == vtp_pkg::OP_LOAD_SCREEN);
      a_tag.idx    <= coeff_index;
      a_tag.coeff  <= coeff_value;
      a_tag.norm_x <= norm_x;
      a_tag.norm_y <= norm_y;
      a_tag.norm_z <= norm_z;
      a_pos[0]     <= pos_x;
      a_pos[1]     <= pos_y;
      a_pos[2]     <= pos_z;
    end
  end

  vtp_mat #(.FRAC_BITS(FRAC_BITS), .NROW(4)) u_proj (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(a_vld), .in_tag(a_tag), .in_vec(a_pos), .in_fault(1'b0), .mat(proj),
    .out_vld(c_vld), .out_tag(c_tag), .out_row(c_row), .out_fault(c_fault)
  );

  vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(c_vld), .in_tag(c_tag), .in_clip(c_row), .in_fault(c_fault),
    .out_vld(n_vld), .out_tag(n_tag), .out_ndc(n_ndc), .out_fault(n_fault)
  );

  // drop screen loads here; only vertices go on
  vtp_mat #(.FRAC_BITS(FRAC_BITS), .NROW(3)) u_screen (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(n_vld && n_tag.vtx), .in_tag(n_tag), .in_vec(n_ndc), .in_fault(n_fault),
    .mat(scr),
    .out_vld(out_valid), .out_tag(o_tag), .out_row(o_row), .out_fault(range_fault)
  );

  assign screen_x   = o_row[0];
  assign screen_y   = o_row[1];
  assign screen_z   = o_row[2];
  assign out_norm_x = o_tag.norm_x;
  assign out_norm_y = o_tag.norm_y;
  assign out_norm_z = o_tag.norm_z;

endmodule

FILE: hw/rtl/vtp_mat.sv
// Three-stage matrix row unit: products, row sums, shift, translate, saturate.
// Depends on vtp_pkg; the matrix is read from the parent at the first stage.
`timescale 1ns / 1ps
module vtp_mat #(
  parameter int FRAC_BITS = 16,
  parameter int NROW      = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  vtp_pkg::tag_t in_tag,
  input  vtp_pkg::fix_t in_vec [3],
  input  logic          in_fault,
  input  vtp_pkg::fix_t mat [16],
  output logic          out_vld,
  output vtp_pkg::tag_t out_tag,
  output vtp_pkg::fix_t out_row [NROW],
  output logic          out_fault
);

  logic                p_vld, s_vld;
  vtp_pkg::tag_t       p_tag, s_tag;
  logic                p_fault, s_fault;
  logic signed [63:0]  p_prod [NROW][3];
  vtp_pkg::fix_t       p_trans [NROW];
  logic signed [65:0]  s_sum [NROW];
  vtp_pkg::fix_t       s_trans [NROW];
  logic signed [vtp_pkg::SW-1:0] row_full [NROW];
  logic                row_ovf;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld   <= 1'b0;
      s_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      p_vld   <= in_vld;
      s_vld   <= p_vld;
      out_vld <= s_vld;
    end
  end

  // translate and check range
  always_comb begin
    row_ovf = 1'b0;
    for (int r = 0; r < NROW; r++) begin
      row_full[r] = vtp_pkg::SW'(s_trans[r]) + vtp_pkg::SW'(s_sum[r] >>> FRAC_BITS);
      row_ovf     = row_ovf | vtp_pkg::sat_ovf(row_full[r]);
    end
  end

  // products, sums, saturated rows
  always_ff @(posedge clk) begin
    if (adv) begin
      p_tag   <= in_tag;
      p_fault <= in_fault;
      for (int r = 0; r < NROW; r++) begin
        for (int k = 0; k < 3; k++) begin
          p_prod[r][k] <= mat[k*4+r] * in_vec[k];
        end
        p_trans[r] <= mat[12+r];
      end
      s_tag   <= p_tag;
      s_fault <= p_fault;
      for (int r = 0; r < NROW; r++) begin
        s_sum[r]   <= 66'(p_prod[r][0]) + 66'(p_prod[r][1]) + 66'(p_prod[r][2]);
        s_trans[r] <= p_trans[r];
      end
      out_tag   <= s_tag;
      out_fault <= s_fault | row_ovf;
      for (int r = 0; r < NROW; r++) begin
        out_row[r] <= vtp_pkg::sat_val(row_full[r]);
      end
    end
  end

endmodule

FILE: hw/rtl/vtp_div.sv
// Pipelined restoring divider: x, y, z shifted by the fraction width over w.
// Depends on vtp_pkg; two quotient bits per stage, three lanes share the divisor.
`timescale 1ns / 1ps
module vtp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  vtp_pkg::tag_t in_tag,
  input  vtp_pkg::fix_t in_clip [4],
  input  logic          in_fault,
  output logic          out_vld,
  output vtp_pkg::tag_t out_tag,
  output vtp_pkg::fix_t out_ndc [3],
  output logic          out_fault
);

  localparam int NW     = vtp_pkg::DW + FRAC_BITS;
  localparam int STEPS  = 2;
  localparam int NSTAGE = vtp_pkg::DW / STEPS;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    logic neg;
    logic cpos;
    logic cneg;
    logic ovf;
  } info_t;

  function automatic lane_t div_step(input lane_t l, input logic [31:0] d);
    logic [32:0] r;
    lane_t       n;
    r     = {l.rem, l.low[31]};
    n.low = {l.low[30:0], 1'b0};
    if (r >= {1'b0, d}) begin
      n.rem = 32'(r - {1'b0, d});
      n.quo = {l.quo[30:0], 1'b1};
    end else begin
      n.rem = r[31:0];
      n.quo = {l.quo[30:0], 1'b0};
    end
    return n;
  endfunction

  logic          s_vld   [NSTAGE+1];
  vtp_pkg::tag_t s_tag   [NSTAGE+1];
  logic          s_fault [NSTAGE+1];
  logic [31:0]   s_d     [NSTAGE+1];
  logic          s_wz    [NSTAGE+1];
  lane_t         s_lane  [NSTAGE+1][3];
  info_t         s_info  [NSTAGE+1][3];

  logic [31:0]   wmag;
  logic [31:0]   cmag [3];
  logic [NW-1:0] num  [3];
  vtp_pkg::fix_t fin_val [3];
  logic          fin_fault;

  // set up magnitudes, high remainder and overflow check
  always_comb begin
    wmag = in_clip[3][31] ? (~in_clip[3] + 32'd1) : in_clip[3];
    for (int i = 0; i < 3; i++) begin
      cmag[i] = in_clip[i][31] ? (~in_clip[i] + 32'd1) : in_clip[i];
      num[i]  = {cmag[i], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else if (adv) begin
      s_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_tag[0]   <= in_tag;
      s_fault[0] <= in_fault;
      s_d[0]     <= wmag;
      s_wz[0]    <= (in_clip[3] == '0);
      for (int i = 0; i < 3; i++) begin
        s_lane[0][i].rem  <= 32'(num[i][NW-1:32]);
        s_lane[0][i].low  <= num[i][31:0];
        s_lane[0][i].quo  <= '0;
        s_info[0][i].neg  <= in_clip[i][31] ^ in_clip[3][31];
        s_info[0][i].cpos <= !in_clip[i][31] && (in_clip[i] != '0);
        s_info[0][i].cneg <= in_clip[i][31];
        s_info[0][i].ovf  <= (32'(num[i][NW-1:32]) >= wmag);
      end
    end
  end

  // quotient stages
  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    lane_t nxt [3];

    always_comb begin
      lane_t l;
      for (int i = 0; i < 3; i++) begin
        l = s_lane[s][i];
        for (int j = 0; j < STEPS; j++) begin
          l = div_step(l, s_d[s]);
        end
        nxt[i] = l;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[s+1] <= 1'b0;
      end else if (adv) begin
        s_vld[s+1] <= s_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_tag[s+1]   <= s_tag[s];
        s_fault[s+1] <= s_fault[s];
        s_d[s+1]     <= s_d[s];
        s_wz[s+1]    <= s_wz[s];
        for (int i = 0; i < 3; i++) begin
          s_lane[s+1][i] <= nxt[i];
          s_info[s+1][i] <= s_info[s][i];
        end
      end
    end
  end

  // sign, zero divisor and saturation
  always_comb begin
    fin_fault = s_fault[NSTAGE];
    for (int i = 0; i < 3; i++) begin
      if (s_wz[NSTAGE]) begin
        fin_fault  = 1'b1;
        fin_val[i] = s_info[NSTAGE][i].cpos ? vtp_pkg::FIX_MAX :
                     s_info[NSTAGE][i].cneg ? vtp_pkg::FIX_MIN : '0;
      end else if (s_info[NSTAGE][i].ovf) begin
        fin_fault  = 1'b1;
        fin_val[i] = s_info[NSTAGE][i].neg ? vtp_pkg::FIX_MIN : vtp_pkg::FIX_MAX;
      end else if (!s_info[NSTAGE][i].neg) begin
        if (s_lane[NSTAGE][i].quo[31]) begin
          fin_fault  = 1'b1;
          fin_val[i] = vtp_pkg::FIX_MAX;
        end else begin
          fin_val[i] = s_lane[NSTAGE][i].quo;
        end
      end else if (s_lane[NSTAGE][i].quo > 32'h8000_0000) begin
        fin_fault  = 1'b1;
        fin_val[i] = vtp_pkg::FIX_MIN;
      end else begin
        fin_val[i] = ~s_lane[NSTAGE][i].quo + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= s_vld[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag   <= s_tag[NSTAGE];
      out_fault <= fin_fault;
      for (int i = 0; i < 3; i++) begin
        out_ndc[i] <= fin_val[i];
      end
    end
  end

endmodule
